// ----- src/svf_pkg.sv -----
// ----------------------------------------------------------------------------
// svf_pkg: shared types and constants for the state-variable filter
// Control word layout, microprogram table, fixed-point limits and saturation.
// ----------------------------------------------------------------------------
package svf_pkg;

    localparam int LANES_DEF = 16;
    localparam int PC_W      = 4;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 49;
    localparam int SUM_W     = 40;

    localparam logic [15:0] CUT_MIN = 16'd66;
    localparam logic [15:0] CUT_MAX = 16'd64881;
    localparam logic [15:0] Q_MIN   = 16'd205;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_Q_BAND,
        MUL_F_HIGH,
        MUL_F_BAND
    } mul_sel_t;

    typedef enum logic [2:0] {
        ALU_NONE,
        ALU_WRAP,
        ALU_LOAD,
        ALU_HIGH,
        ALU_BAND,
        ALU_LOW
    } alu_op_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_WHILE_WRAP,
        SEQ_WAIT_OUT
    } seq_t;

    typedef struct packed {
        logic             capture;
        logic             mem_rd;
        logic             mem_wr;
        logic             finish;
        mul_sel_t         mul;
        alu_op_t          alu;
        seq_t             seq;
        logic [PC_W-1:0]  target;
    } uword_t;

    typedef struct packed {
        logic in_valid;
        logic lane_big;
        logic out_free;
    } status_t;

    localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] PC_WRAP  = 4'd1;
    localparam logic [PC_W-1:0] PC_READ  = 4'd2;
    localparam logic [PC_W-1:0] PC_LOAD  = 4'd3;
    localparam logic [PC_W-1:0] PC_MULQ  = 4'd4;
    localparam logic [PC_W-1:0] PC_HIGH  = 4'd5;
    localparam logic [PC_W-1:0] PC_MULH  = 4'd6;
    localparam logic [PC_W-1:0] PC_BAND  = 4'd7;
    localparam logic [PC_W-1:0] PC_MULB  = 4'd8;
    localparam logic [PC_W-1:0] PC_LOW   = 4'd9;
    localparam logic [PC_W-1:0] PC_WRITE = 4'd10;

    // Microprogram: one control word per step.
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '0;
        case (pc)
            PC_IDLE:
            begin
                w.capture = 1'b1;
                w.seq     = SEQ_WAIT_IN;
            end
            PC_WRAP:
            begin
                w.alu = ALU_WRAP;
                w.seq = SEQ_WHILE_WRAP;
            end
            PC_READ:  w.mem_rd = 1'b1;
            PC_LOAD:  w.alu    = ALU_LOAD;
            PC_MULQ:  w.mul    = MUL_Q_BAND;
            PC_HIGH:  w.alu    = ALU_HIGH;
            PC_MULH:  w.mul    = MUL_F_HIGH;
            PC_BAND:  w.alu    = ALU_BAND;
            PC_MULB:  w.mul    = MUL_F_BAND;
            PC_LOW:   w.alu    = ALU_LOW;
            PC_WRITE:
            begin
                w.mem_wr = 1'b1;
                w.finish = 1'b1;
                w.seq    = SEQ_WAIT_OUT;
                w.target = PC_IDLE;
            end
            default:
            begin
                w.seq    = SEQ_WAIT_OUT;
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = 40'sd2147483647;
        lo = -40'sd2147483648;
        if (v > hi)
            return hi[DATA_W-1:0];
        else if (v < lo)
            return lo[DATA_W-1:0];
        else
            return v[DATA_W-1:0];
    endfunction

endpackage

// ----- src/svf_lane_ram.sv -----
// ----------------------------------------------------------------------------
// svf_lane_ram: per-lane integrator store
// Low and band state memories with registered read and per-entry valid bits;
// an entry never written reads as zero.
// ----------------------------------------------------------------------------
module svf_lane_ram #(
    parameter int LANES = svf_pkg::LANES_DEF,
    parameter int IDX_W = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               rd_en,
    input  logic                               wr_en,
    input  logic [IDX_W-1:0]                   addr,
    input  logic signed [svf_pkg::DATA_W-1:0]  wr_low,
    input  logic signed [svf_pkg::DATA_W-1:0]  wr_band,
    output logic signed [svf_pkg::DATA_W-1:0]  rd_low,
    output logic signed [svf_pkg::DATA_W-1:0]  rd_band
);

    logic signed [svf_pkg::DATA_W-1:0] low_mem  [LANES];
    logic signed [svf_pkg::DATA_W-1:0] band_mem [LANES];
    logic [LANES-1:0]                  valid_reg;
    logic                              rd_vld_reg;
    logic signed [svf_pkg::DATA_W-1:0] rd_low_reg;
    logic signed [svf_pkg::DATA_W-1:0] rd_band_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            low_mem[addr]  <= wr_low;
            band_mem[addr] <= wr_band;
        end
        if (rd_en)
        begin
            rd_low_reg  <= low_mem[addr];
            rd_band_reg <= band_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[addr] <= 1'b1;
            if (rd_en)
                rd_vld_reg <= valid_reg[addr];
        end
    end

    assign rd_low  = rd_vld_reg ? rd_low_reg  : '0;
    assign rd_band = rd_vld_reg ? rd_band_reg : '0;

endmodule

// ----- src/svf_seq.sv -----
// ----------------------------------------------------------------------------
// svf_seq: microprogram sequencer
// Step counter over the control table with wait and loop conditions.
// ----------------------------------------------------------------------------
module svf_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  svf_pkg::status_t  stat,
    output svf_pkg::uword_t   cw
);

    logic [svf_pkg::PC_W-1:0] pc_reg;
    logic [svf_pkg::PC_W-1:0] pc_next;

    assign cw = svf_pkg::ucode(pc_reg);

    always_comb
    begin
        case (cw.seq)
            svf_pkg::SEQ_NEXT:       pc_next = pc_reg + 1'b1;
            svf_pkg::SEQ_WAIT_IN:    pc_next = stat.in_valid ? pc_reg + 1'b1 : pc_reg;
            svf_pkg::SEQ_WHILE_WRAP: pc_next = stat.lane_big ? pc_reg : pc_reg + 1'b1;
            svf_pkg::SEQ_WAIT_OUT:   pc_next = stat.out_free ? cw.target : pc_reg;
            default:                 pc_next = svf_pkg::PC_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= svf_pkg::PC_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

// ----- src/svf_datapath.sv -----
// ----------------------------------------------------------------------------
// svf_datapath: filter datapath
// Operand registers, one shared 17x32 multiplier, rounding adder with
// saturation, and the output register.
// ----------------------------------------------------------------------------
module svf_datapath #(
    parameter int LANES = svf_pkg::LANES_DEF,
    parameter int IDX_W = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  svf_pkg::uword_t                    cw,
    output svf_pkg::status_t                   stat,
    input  logic                               in_valid,
    input  logic signed [23:0]                 sample_in,
    input  logic [15:0]                        cutoff,
    input  logic [15:0]                        damping,
    input  logic [1:0]                         mode,
    input  logic [3:0]                         lane,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [31:0]                 filtered_out,
    output logic [IDX_W-1:0]                   mem_idx,
    input  logic signed [svf_pkg::DATA_W-1:0]  rd_low,
    input  logic signed [svf_pkg::DATA_W-1:0]  rd_band,
    output logic signed [svf_pkg::DATA_W-1:0]  wr_low,
    output logic signed [svf_pkg::DATA_W-1:0]  wr_band
);

    localparam logic [1:0] MODE_BAND = 2'd1;
    localparam logic [1:0] MODE_HIGH = 2'd2;

    localparam int DW = svf_pkg::DATA_W;
    localparam int PW = svf_pkg::PROD_W;
    localparam int SW = svf_pkg::SUM_W;

    logic signed [DW-1:0] x_reg;
    logic [15:0]          f_reg;
    logic [15:0]          q_reg;
    logic [1:0]           mode_reg;
    logic [3:0]           lane_reg;
    logic signed [DW-1:0] low_reg;
    logic signed [DW-1:0] band_reg;
    logic signed [DW-1:0] high_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [DW-1:0] out_reg;
    logic                 out_valid_reg;

    logic [15:0]          f_clamp;
    logic [15:0]          q_clamp;
    logic                 lane_big;
    logic                 out_free;
    logic signed [16:0]   coef;
    logic signed [DW-1:0] mul_b;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] p12;
    logic signed [PW-1:0] p16;
    logic signed [SW-1:0] r12;
    logic signed [SW-1:0] r16;
    logic signed [DW-1:0] high_next;
    logic signed [DW-1:0] band_next;
    logic signed [DW-1:0] low_next;
    logic signed [DW-1:0] sel;

    always_comb
    begin
        if (cutoff < svf_pkg::CUT_MIN)
            f_clamp = svf_pkg::CUT_MIN;
        else if (cutoff > svf_pkg::CUT_MAX)
            f_clamp = svf_pkg::CUT_MAX;
        else
            f_clamp = cutoff;
        q_clamp = (damping < svf_pkg::Q_MIN) ? svf_pkg::Q_MIN : damping;
    end

    assign lane_big = 32'(lane_reg) >= LANES;
    assign out_free = !out_valid_reg || out_ready;
    assign mem_idx  = IDX_W'(lane_reg);

    assign stat.in_valid = in_valid;
    assign stat.lane_big = lane_big;
    assign stat.out_free = out_free;

    // Shared multiplier operand selection.
    always_comb
    begin
        case (cw.mul)
            svf_pkg::MUL_Q_BAND:
            begin
                coef  = signed'({1'b0, q_reg});
                mul_b = band_reg;
            end
            svf_pkg::MUL_F_HIGH:
            begin
                coef  = signed'({1'b0, f_reg});
                mul_b = high_reg;
            end
            default:
            begin
                coef  = signed'({1'b0, f_reg});
                mul_b = band_reg;
            end
        endcase
        prod_next = coef * mul_b;
    end

    // Round to nearest by adding half an LSB, then an arithmetic shift (floor).
    assign p12 = (prod_reg + 49'sd2048) >>> 12;
    assign p16 = (prod_reg + 49'sd32768) >>> 16;
    assign r12 = signed'(p12[SW-1:0]);
    assign r16 = signed'(p16[SW-1:0]);

    assign high_next = svf_pkg::sat32(SW'(x_reg) - SW'(low_reg) - r12);
    assign band_next = svf_pkg::sat32(SW'(band_reg) + r16);
    assign low_next  = svf_pkg::sat32(SW'(low_reg) + r16);

    always_comb
    begin
        case (mode_reg)
            MODE_BAND: sel = band_reg;
            MODE_HIGH: sel = high_reg;
            default:   sel = low_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cw.capture && in_valid)
        begin
            x_reg    <= DW'(sample_in);
            f_reg    <= f_clamp;
            q_reg    <= q_clamp;
            mode_reg <= mode;
            lane_reg <= lane;
        end
        if (cw.mul != svf_pkg::MUL_NONE)
            prod_reg <= prod_next;
        case (cw.alu)
            svf_pkg::ALU_WRAP:
            begin
                if (lane_big)
                    lane_reg <= lane_reg - 4'(LANES);
            end
            svf_pkg::ALU_LOAD:
            begin
                low_reg  <= rd_low;
                band_reg <= rd_band;
            end
            svf_pkg::ALU_HIGH: high_reg <= high_next;
            svf_pkg::ALU_BAND: band_reg <= band_next;
            svf_pkg::ALU_LOW:  low_reg  <= low_next;
            default:
            begin
            end
        endcase
        if (cw.finish && out_free)
            out_reg <= sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cw.finish && out_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid    = out_valid_reg;
    assign filtered_out = out_reg;
    assign wr_low       = low_reg;
    assign wr_band      = band_reg;

    // The state store is only addressed once the lane has been reduced.
    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cw.mem_rd |-> !lane_big)
        else $error("state read with lane out of range");

    a_high_after_qmul: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.alu == svf_pkg::ALU_HIGH) |-> ($past(cw.mul) == svf_pkg::MUL_Q_BAND))
        else $error("high computed without a fresh q*band product");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cw.finish))
        else $error("result shown without a finish step");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.capture && in_valid) |=> !cw.capture)
        else $error("sequencer stayed idle after a transfer");

endmodule

// ----- src/state_variable_filter_lanes.sv -----
// ----------------------------------------------------------------------------
// state_variable_filter_lanes: multi-lane Chamberlin state-variable filter
// Fixed-point SVF with per-lane low and band integrators, microcoded.
// ----------------------------------------------------------------------------
// Each transfer carries a sample, cutoff, damping, output mode and lane. A
// short microprogram runs the item over one shared 17x32 multiplier and one
// rounding adder with saturation: q*band, high, f*high, band, f*band, low,
// then a write back of the lane's integrators. The result register is loaded
// at the write back step, and no new input is taken before the item is done.
// For LANES below 16 the lane wrap step repeats a subtraction of LANES until
// the lane number is below LANES. The microprogram runs capture, lane wrap,
// state read and load, three multiply and add pairs that each depend on the
// one before, and the write back. The result sits in an output register;
// while an earlier result is still waiting there, the sequencer holds at the
// write back step, and the next input is taken once the sequencer is back at
// its first step. Integrator state is zero after reset with no clearing pass.
module state_variable_filter_lanes #(
    parameter int LANES = svf_pkg::LANES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [23:0]  sample_in,
    input  logic [15:0]         cutoff,
    input  logic [15:0]         damping,
    input  logic [1:0]          mode,
    input  logic [3:0]          lane,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  filtered_out
);

    localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

    svf_pkg::uword_t                    cw;
    svf_pkg::status_t                   stat;
    logic [IDX_W-1:0]                   mem_idx;
    logic signed [svf_pkg::DATA_W-1:0]  rd_low;
    logic signed [svf_pkg::DATA_W-1:0]  rd_band;
    logic signed [svf_pkg::DATA_W-1:0]  wr_low;
    logic signed [svf_pkg::DATA_W-1:0]  wr_band;

    assign in_ready = cw.capture;

    svf_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cw    (cw)
    );

    svf_datapath #(
        .LANES (LANES),
        .IDX_W (IDX_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cw           (cw),
        .stat         (stat),
        .in_valid     (in_valid),
        .sample_in    (sample_in),
        .cutoff       (cutoff),
        .damping      (damping),
        .mode         (mode),
        .lane         (lane),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .filtered_out (filtered_out),
        .mem_idx      (mem_idx),
        .rd_low       (rd_low),
        .rd_band      (rd_band),
        .wr_low       (wr_low),
        .wr_band      (wr_band)
    );

    svf_lane_ram #(
        .LANES (LANES),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (cw.mem_rd),
        .wr_en   (cw.mem_wr),
        .addr    (mem_idx),
        .wr_low  (wr_low),
        .wr_band (wr_band),
        .rd_low  (rd_low),
        .rd_band (rd_band)
    );

endmodule
